@@ rtl/bgsb_pkg.sv @@
package bgsb_pkg;

    localparam int STORE_BYTES_DEF = 4096;

    localparam logic [3:0] ACT_PUT_BIT     = 4'd0;
    localparam logic [3:0] ACT_GET_BIT     = 4'd1;
    localparam logic [3:0] ACT_PUT_BYTE    = 4'd2;
    localparam logic [3:0] ACT_GET_BYTE    = 4'd3;
    localparam logic [3:0] ACT_READ_SEEK   = 4'd4;
    localparam logic [3:0] ACT_WRITE_SEEK  = 4'd5;
    localparam logic [3:0] ACT_SKIP        = 4'd6;
    localparam logic [3:0] ACT_BACK        = 4'd7;
    localparam logic [3:0] ACT_READ_ALIGN  = 4'd8;
    localparam logic [3:0] ACT_WRITE_ALIGN = 4'd9;
    localparam logic [3:0] ACT_RESTART     = 4'd10;

    localparam logic [1:0] REG_MSB_FIRST     = 2'd0;
    localparam logic [1:0] REG_LIMIT_BYTES   = 2'd1;
    localparam logic [1:0] REG_WRITE_PROTECT = 2'd2;

    localparam logic [12:0] LIMIT_RESET = 13'd4096;
    localparam logic [7:0]  FAIL_BYTE   = 8'hFF;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  data;
        logic [12:0] target_byte;
        logic [2:0]  target_bit;
        logic [15:0] bit_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        success;
        logic        read_fault;
        logic        write_fault;
        logic [15:0] read_position;
        logic [15:0] write_position;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic rd_lo;
        logic rd_hi;
        logic exec;
        logic wr_hi;
    } t_cmd;

    typedef struct packed {
        logic in_needs_read;
        logic hi_write;
    } t_status;

endpackage

@@ rtl/bgsb_ctrl.sv @@
module bgsb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  bgsb_pkg::t_status i_status,
    output bgsb_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_WR1  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.in_needs_read ? S_RD0 : S_EXEC;
                end
            end
            S_RD0: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = i_status.hi_write ? S_WR1 : S_IDLE;
                end
            end
            S_WR1: begin
                o_cmd.wr_hi = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/bgsb_datapath.sv @@
module bgsb_datapath #(
    parameter int STORE_BYTES = bgsb_pkg::STORE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    input  bgsb_pkg::t_in_item  i_item,
    input  bgsb_pkg::t_cmd      i_cmd,
    output bgsb_pkg::t_status   o_status,
    output bgsb_pkg::t_out_item o_result
);

    localparam int          AW        = $clog2(STORE_BYTES);
    localparam logic [16:0] STORE_W17 = 17'(STORE_BYTES);

    logic [7:0] mem [STORE_BYTES];

    logic        r_msb_first, r_wprot;
    logic [12:0] r_limit;
    logic [15:0] r_rp, r_wp, n_rp, n_wp;
    logic        r_rerr, r_werr, n_rerr, n_werr;
    bgsb_pkg::t_in_item  r_item;
    bgsb_pkg::t_out_item r_out;
    logic [AW-1:0] r_lo_addr, r_hi_addr;
    logic [7:0]  r_rdq, r_a, r_hi_wd;

    logic [12:0] lim;
    logic [12:0] rbyte, wbyte, ld_byte;
    logic [2:0]  rbit, wbit;
    logic [16:0] lo_idx17, hi_idx17;
    logic [15:0] target, lim_bits;
    logic [13:0] wbyte_p1;
    logic [7:0]  tail, bmask, rd;
    logic        ok, lo_we, hi_we;
    logic [7:0]  lo_wd, hi_wd;
    logic [15:0] msb_shift, lsb_shift, get_msb, get_lsb;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]  mem_wdata;

    assign lim   = ({4'b0, r_limit} < STORE_W17) ? r_limit : STORE_W17[12:0];
    assign rbyte = r_rp[15:3];
    assign rbit  = r_rp[2:0];
    assign wbyte = r_wp[15:3];
    assign wbit  = r_wp[2:0];
    assign wbyte_p1 = {1'b0, wbyte} + 14'd1;
    assign target   = {r_item.target_byte, r_item.target_bit};
    assign lim_bits = {lim, 3'b000};

    assign ld_byte  = (i_item.action == bgsb_pkg::ACT_GET_BIT ||
                       i_item.action == bgsb_pkg::ACT_GET_BYTE) ? rbyte : wbyte;
    assign lo_idx17 = ({4'b0, ld_byte} == STORE_W17) ? 17'd0 : {4'b0, ld_byte};
    assign hi_idx17 = ({4'b0, ld_byte} + 17'd1 == STORE_W17) ? 17'd0
                                                              : {4'b0, ld_byte} + 17'd1;

    assign o_status.in_needs_read = (i_item.action == bgsb_pkg::ACT_PUT_BIT  ||
                                     i_item.action == bgsb_pkg::ACT_GET_BIT  ||
                                     i_item.action == bgsb_pkg::ACT_PUT_BYTE ||
                                     i_item.action == bgsb_pkg::ACT_GET_BYTE ||
                                     i_item.action == bgsb_pkg::ACT_WRITE_ALIGN);
    assign o_status.hi_write = hi_we;

    always_comb begin
        tail      = r_msb_first ? (8'hFF >> wbit) : (8'hFF << wbit);
        bmask     = r_msb_first ? (8'h80 >> (r_item.action == bgsb_pkg::ACT_GET_BIT ?
                                             rbit : wbit))
                                : (8'h01 << (r_item.action == bgsb_pkg::ACT_GET_BIT ?
                                             rbit : wbit));
        msb_shift = {r_item.data, 8'h00} >> wbit;
        lsb_shift = {8'h00, r_item.data} << wbit;
        get_msb   = {r_a, r_rdq} << rbit;
        get_lsb   = {r_rdq, r_a} >> rbit;
        n_rp   = r_rp;
        n_wp   = r_wp;
        n_rerr = r_rerr;
        n_werr = r_werr;
        rd     = 8'h00;
        ok     = 1'b0;
        lo_we  = 1'b0;
        lo_wd  = r_a;
        hi_we  = 1'b0;
        hi_wd  = 8'h00;
        unique case (r_item.action)
            bgsb_pkg::ACT_PUT_BIT: begin
                if (r_wprot || r_werr || wbyte >= lim) begin
                    n_werr = 1'b1;
                end else begin
                    lo_we = 1'b1;
                    lo_wd = r_item.data[0] ? (r_a | bmask) : (r_a & ~bmask);
                    n_wp  = r_wp + 16'd1;
                    ok    = 1'b1;
                end
            end
            bgsb_pkg::ACT_GET_BIT: begin
                if (r_rerr || r_rp >= r_wp) begin
                    n_rerr = 1'b1;
                    rd     = {7'b0, r_item.data[0]};
                end else begin
                    rd   = {7'b0, |(r_a & bmask)};
                    n_rp = r_rp + 16'd1;
                    ok   = 1'b1;
                end
            end
            bgsb_pkg::ACT_PUT_BYTE: begin
                if (r_wprot || r_werr || wbyte >= lim) begin
                    n_werr = 1'b1;
                end else if (wbit == 3'd0) begin
                    lo_we = 1'b1;
                    lo_wd = r_item.data;
                    n_wp  = r_wp + 16'd8;
                    ok    = 1'b1;
                end else if (wbyte_p1 == {1'b0, lim}) begin
                    lo_we  = 1'b1;
                    lo_wd  = r_a & ~tail;
                    n_werr = 1'b1;
                end else begin
                    lo_we = 1'b1;
                    hi_we = 1'b1;
                    lo_wd = (r_a & ~tail) | (r_msb_first ? msb_shift[15:8] : lsb_shift[7:0]);
                    hi_wd = r_msb_first ? msb_shift[7:0] : lsb_shift[15:8];
                    n_wp  = r_wp + 16'd8;
                    ok    = 1'b1;
                end
            end
            bgsb_pkg::ACT_GET_BYTE: begin
                if (r_rerr || ({1'b0, r_rp} + 17'd8 > {1'b0, r_wp})) begin
                    n_rerr = 1'b1;
                    rd     = bgsb_pkg::FAIL_BYTE;
                end else begin
                    rd   = r_msb_first ? get_msb[15:8] : get_lsb[7:0];
                    n_rp = r_rp + 16'd8;
                    ok   = 1'b1;
                end
            end
            bgsb_pkg::ACT_READ_SEEK: begin
                if (target > r_wp) begin
                    n_rp   = r_wp;
                    n_rerr = 1'b1;
                end else begin
                    n_rp = target;
                    ok   = 1'b1;
                end
            end
            bgsb_pkg::ACT_WRITE_SEEK: begin
                if (r_wprot) begin
                    n_werr = 1'b1;
                end else if (target < r_rp) begin
                    n_wp   = r_rp;
                    n_werr = 1'b1;
                end else if (target > lim_bits) begin
                    n_wp   = (lim_bits > r_rp) ? lim_bits : r_rp;
                    n_werr = 1'b1;
                end else begin
                    n_wp = target;
                    ok   = 1'b1;
                end
            end
            bgsb_pkg::ACT_SKIP: begin
                if (!r_rerr) begin
                    if ({1'b0, r_rp} + {1'b0, r_item.bit_count} > {1'b0, r_wp}) begin
                        n_rp   = r_wp;
                        n_rerr = 1'b1;
                    end else begin
                        n_rp = r_rp + r_item.bit_count;
                        ok   = 1'b1;
                    end
                end
            end
            bgsb_pkg::ACT_BACK: begin
                if (!r_rerr) begin
                    if (r_item.bit_count > r_rp) begin
                        n_rp   = 16'd0;
                        n_rerr = 1'b1;
                    end else begin
                        n_rp = r_rp - r_item.bit_count;
                        ok   = 1'b1;
                    end
                end
            end
            bgsb_pkg::ACT_READ_ALIGN: begin
                if (rbit == 3'd0) begin
                    ok = 1'b1;
                end else if (rbyte >= wbyte) begin
                    n_rerr = 1'b1;
                end else begin
                    n_rp = {rbyte + 13'd1, 3'b000};
                    ok   = 1'b1;
                end
            end
            bgsb_pkg::ACT_WRITE_ALIGN: begin
                if (r_wprot) begin
                    n_werr = 1'b1;
                end else if (wbit == 3'd0) begin
                    ok = 1'b1;
                end else if (wbyte >= lim) begin
                    n_werr = 1'b1;
                end else begin
                    lo_we = 1'b1;
                    lo_wd = r_item.data[0] ? (r_a | tail) : (r_a & ~tail);
                    n_wp  = {wbyte + 13'd1, 3'b000};
                    ok    = 1'b1;
                end
            end
            bgsb_pkg::ACT_RESTART: begin
                n_rp   = 16'd0;
                n_wp   = 16'd0;
                n_rerr = 1'b0;
                n_werr = 1'b0;
                ok     = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign mem_we    = (i_cmd.exec && lo_we) || i_cmd.wr_hi;
    assign mem_waddr = i_cmd.wr_hi ? r_hi_addr : r_lo_addr;
    assign mem_wdata = i_cmd.wr_hi ? r_hi_wd : lo_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_lo || i_cmd.rd_hi) begin
            r_rdq <= mem[i_cmd.rd_hi ? r_hi_addr : r_lo_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item    <= i_item;
            r_lo_addr <= lo_idx17[AW-1:0];
            r_hi_addr <= hi_idx17[AW-1:0];
        end
        if (i_cmd.rd_hi) begin
            r_a <= r_rdq;
        end
        if (i_cmd.exec) begin
            r_hi_wd <= hi_wd;
            r_out   <= '{read_data: rd, success: ok, read_fault: n_rerr,
                         write_fault: n_werr, read_position: n_rp,
                         write_position: n_wp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb_first <= 1'b1;
            r_limit     <= bgsb_pkg::LIMIT_RESET;
            r_wprot     <= 1'b0;
            r_rp        <= 16'd0;
            r_wp        <= 16'd0;
            r_rerr      <= 1'b0;
            r_werr      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    bgsb_pkg::REG_MSB_FIRST:     r_msb_first <= i_cfg_data[0];
                    bgsb_pkg::REG_LIMIT_BYTES:   r_limit     <= i_cfg_data;
                    bgsb_pkg::REG_WRITE_PROTECT: r_wprot     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_rp   <= n_rp;
                r_wp   <= n_wp;
                r_rerr <= n_rerr;
                r_werr <= n_werr;
            end
        end
    end

    assign o_result = r_out;

endmodule

@@ rtl/bit_granular_stream_buffer.sv @@
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_ready  i_item   (bgsb_pkg::t_in_item)
// result    out        o_valid / i_ready  o_result (bgsb_pkg::t_out_item)
// config    in         i_cfg_wr_en        i_cfg_index, i_cfg_data
//
// A request that touches the store (bit or byte put and get, write align) passes
// through load, two reads and execute, plus a high-byte write for an unaligned
// byte put: up to two writes on the single store port. Others skip the reads.
// The result register frees the request side; a request waits in its execute step
// only while the previous result has not been taken.
// Synchronous active-low reset clears the pointers, the error flags and the result
// valid flag and sets the config registers to defaults; the store is undefined until written.
module bit_granular_stream_buffer #(
    parameter int STORE_BYTES = bgsb_pkg::STORE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  bgsb_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output bgsb_pkg::t_out_item o_result
);

    bgsb_pkg::t_cmd    cmd;
    bgsb_pkg::t_status status;

    bgsb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bgsb_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (o_result)
    );

endmodule
